// File: rtl/ccp_pkg.sv
// ----------------------------------------------------------------------------
// ccp_pkg
// Types and constants shared by the constant pool parser files.
// ----------------------------------------------------------------------------
package ccp_pkg;

  typedef enum logic [3:0] {
    PH_COUNT_HI = 4'd0,
    PH_COUNT_LO = 4'd1,
    PH_TAG      = 4'd2,
    PH_LEN_HI   = 4'd3,
    PH_LEN_LO   = 4'd4,
    PH_TEXT     = 4'd5,
    PH_NUMERIC  = 4'd6,
    PH_IDX1     = 4'd7,
    PH_IDX2     = 4'd8,
    PH_KIND     = 4'd9,
    PH_DONE     = 4'd10
  } ccp_phase_t;

  localparam logic [3:0] ROLE_COUNT   = 4'd0;
  localparam logic [3:0] ROLE_TAG     = 4'd1;
  localparam logic [3:0] ROLE_TEXTLEN = 4'd2;
  localparam logic [3:0] ROLE_TEXT    = 4'd3;
  localparam logic [3:0] ROLE_NUMERIC = 4'd4;
  localparam logic [3:0] ROLE_IDX1    = 4'd5;
  localparam logic [3:0] ROLE_IDX2    = 4'd6;
  localparam logic [3:0] ROLE_KIND    = 4'd7;
  localparam logic [3:0] ROLE_IGNORED = 4'd8;

  localparam logic [2:0] ST_BUSY      = 3'd0;
  localparam logic [2:0] ST_COMPLETE  = 3'd1;
  localparam logic [2:0] ST_TRUNCATED = 3'd2;
  localparam logic [2:0] ST_BAD_COUNT = 3'd3;
  localparam logic [2:0] ST_BAD_TAG   = 3'd4;

  localparam logic [7:0] TAG_UTF8        = 8'd1;
  localparam logic [7:0] TAG_INTEGER     = 8'd3;
  localparam logic [7:0] TAG_FLOAT       = 8'd4;
  localparam logic [7:0] TAG_LONG        = 8'd5;
  localparam logic [7:0] TAG_DOUBLE      = 8'd6;
  localparam logic [7:0] TAG_CLASS       = 8'd7;
  localparam logic [7:0] TAG_STRING      = 8'd8;
  localparam logic [7:0] TAG_FIELDREF    = 8'd9;
  localparam logic [7:0] TAG_METHODREF   = 8'd10;
  localparam logic [7:0] TAG_IFMETHODREF = 8'd11;
  localparam logic [7:0] TAG_NAMETYPE    = 8'd12;
  localparam logic [7:0] TAG_MHANDLE     = 8'd15;
  localparam logic [7:0] TAG_MTYPE       = 8'd16;
  localparam logic [7:0] TAG_DYNAMIC     = 8'd17;
  localparam logic [7:0] TAG_INVOKEDYN   = 8'd18;
  localparam logic [7:0] TAG_MODULE      = 8'd19;
  localparam logic [7:0] TAG_PACKAGE     = 8'd20;

  localparam logic [15:0] NUM_LEN_NARROW = 16'd4;
  localparam logic [15:0] NUM_LEN_WIDE   = 16'd8;
  localparam logic [15:0] IDX_LEN        = 16'd2;

  typedef struct packed {
    ccp_phase_t  phase;
    logic [15:0] pool_count;
    logic [15:0] current_slot;
    logic [7:0]  current_tag;
    logic [15:0] field_remaining;
    logic [15:0] field_position;
    logic [7:0]  length_high_byte;
    logic [2:0]  final_status;
  } ccp_state_t;

  localparam ccp_state_t CCP_STATE_RESET = '{
    phase:            PH_COUNT_HI,
    pool_count:       16'd0,
    current_slot:     16'd0,
    current_tag:      8'd0,
    field_remaining:  16'd0,
    field_position:   16'd0,
    length_high_byte: 8'd0,
    final_status:     ST_BUSY
  };

  typedef struct packed {
    logic [15:0] slot_index;
    logic [7:0]  entry_tag;
    logic [3:0]  byte_role;
    logic [15:0] field_offset;
    logic [7:0]  byte_echo;
    logic        entry_complete;
    logic [2:0]  status;
  } ccp_result_t;

endpackage

// File: rtl/ccp_if.sv
// ----------------------------------------------------------------------------
// ccp_if
// Valid/ready channels for input bytes and labelled result words.
// ----------------------------------------------------------------------------
interface ccp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_marker;

  modport source (output valid, output byte_value, output end_marker, input ready);
  modport sink   (input valid, input byte_value, input end_marker, output ready);
endinterface

interface ccp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] slot_index;
  logic [7:0]  entry_tag;
  logic [3:0]  byte_role;
  logic [15:0] field_offset;
  logic [7:0]  byte_echo;
  logic        entry_complete;
  logic [2:0]  status;

  modport source (output valid, output slot_index, output entry_tag, output byte_role,
                  output field_offset, output byte_echo, output entry_complete,
                  output status, input ready);
  modport sink   (input valid, input slot_index, input entry_tag, input byte_role,
                  input field_offset, input byte_echo, input entry_complete,
                  input status, output ready);
endinterface

// File: rtl/ccp_step.sv
// ----------------------------------------------------------------------------
// ccp_step
// Parser next-state and byte labelling logic for one input word.
// ----------------------------------------------------------------------------
module ccp_step (
  input  ccp_pkg::ccp_state_t  st,
  input  logic [7:0]           byte_value,
  input  logic                 end_marker,
  output ccp_pkg::ccp_state_t  st_next,
  output ccp_pkg::ccp_result_t res
);

  logic [16:0] pool17;
  logic [16:0] sum1;
  logic [16:0] sum2;
  logic [15:0] rem_dec;
  logic [15:0] len;

  assign pool17  = {1'b0, st.pool_count};
  assign sum1    = {1'b0, st.current_slot} + 17'd1;
  assign sum2    = {1'b0, st.current_slot} + 17'd2;
  assign rem_dec = (st.field_remaining != 16'd0) ? st.field_remaining - 16'd1 : 16'd0;
  assign len     = {st.length_high_byte, byte_value};

  always_comb begin
    st_next            = st;
    res.slot_index     = st.current_slot;
    res.entry_tag      = st.current_tag;
    res.byte_role      = ccp_pkg::ROLE_IGNORED;
    res.field_offset   = 16'd0;
    res.byte_echo      = byte_value;
    res.entry_complete = 1'b0;
    res.status         = ccp_pkg::ST_BUSY;

    if (end_marker && st.phase != ccp_pkg::PH_DONE) begin
      st_next.phase        = ccp_pkg::PH_DONE;
      st_next.final_status = ccp_pkg::ST_TRUNCATED;
      res.status           = ccp_pkg::ST_TRUNCATED;
      res.byte_echo        = 8'd0;
    end else begin
      case (st.phase)
        ccp_pkg::PH_COUNT_HI: begin
          res.byte_role            = ccp_pkg::ROLE_COUNT;
          st_next.length_high_byte = byte_value;
          st_next.phase            = ccp_pkg::PH_COUNT_LO;
        end
        ccp_pkg::PH_COUNT_LO: begin
          res.byte_role      = ccp_pkg::ROLE_COUNT;
          res.field_offset   = 16'd1;
          st_next.pool_count = len;
          if (len == 16'd0) begin
            st_next.phase        = ccp_pkg::PH_DONE;
            st_next.final_status = ccp_pkg::ST_BAD_COUNT;
            res.status           = ccp_pkg::ST_BAD_COUNT;
          end else begin
            st_next.current_slot = 16'd1;
            if (len == 16'd1) begin
              st_next.phase        = ccp_pkg::PH_DONE;
              st_next.final_status = ccp_pkg::ST_COMPLETE;
              res.status           = ccp_pkg::ST_COMPLETE;
            end else begin
              st_next.phase = ccp_pkg::PH_TAG;
            end
          end
        end
        ccp_pkg::PH_TAG: begin
          res.byte_role       = ccp_pkg::ROLE_TAG;
          res.entry_tag       = byte_value;
          st_next.current_tag = byte_value;
          case (byte_value)
            ccp_pkg::TAG_UTF8: st_next.phase = ccp_pkg::PH_LEN_HI;
            ccp_pkg::TAG_INTEGER, ccp_pkg::TAG_FLOAT: begin
              st_next.phase           = ccp_pkg::PH_NUMERIC;
              st_next.field_remaining = ccp_pkg::NUM_LEN_NARROW;
              st_next.field_position  = 16'd0;
            end
            ccp_pkg::TAG_LONG, ccp_pkg::TAG_DOUBLE: begin
              st_next.phase           = ccp_pkg::PH_NUMERIC;
              st_next.field_remaining = ccp_pkg::NUM_LEN_WIDE;
              st_next.field_position  = 16'd0;
            end
            ccp_pkg::TAG_CLASS, ccp_pkg::TAG_STRING, ccp_pkg::TAG_MTYPE,
            ccp_pkg::TAG_MODULE, ccp_pkg::TAG_PACKAGE, ccp_pkg::TAG_FIELDREF,
            ccp_pkg::TAG_METHODREF, ccp_pkg::TAG_IFMETHODREF, ccp_pkg::TAG_NAMETYPE,
            ccp_pkg::TAG_DYNAMIC, ccp_pkg::TAG_INVOKEDYN: begin
              st_next.phase           = ccp_pkg::PH_IDX1;
              st_next.field_remaining = ccp_pkg::IDX_LEN;
              st_next.field_position  = 16'd0;
            end
            ccp_pkg::TAG_MHANDLE: st_next.phase = ccp_pkg::PH_KIND;
            default: begin
              st_next.phase        = ccp_pkg::PH_DONE;
              st_next.final_status = ccp_pkg::ST_BAD_TAG;
              res.status           = ccp_pkg::ST_BAD_TAG;
            end
          endcase
        end
        ccp_pkg::PH_LEN_HI: begin
          res.byte_role            = ccp_pkg::ROLE_TEXTLEN;
          st_next.length_high_byte = byte_value;
          st_next.phase            = ccp_pkg::PH_LEN_LO;
        end
        ccp_pkg::PH_LEN_LO: begin
          res.byte_role    = ccp_pkg::ROLE_TEXTLEN;
          res.field_offset = 16'd1;
          if (len == 16'd0) begin
            // empty string closes the entry here
            res.entry_complete   = 1'b1;
            st_next.current_slot = sum1[15:0];
            if (sum1 >= pool17) begin
              st_next.phase        = ccp_pkg::PH_DONE;
              st_next.final_status = ccp_pkg::ST_COMPLETE;
              res.status           = ccp_pkg::ST_COMPLETE;
            end else begin
              st_next.phase = ccp_pkg::PH_TAG;
            end
          end else begin
            st_next.phase           = ccp_pkg::PH_TEXT;
            st_next.field_remaining = len;
            st_next.field_position  = 16'd0;
          end
        end
        ccp_pkg::PH_KIND: begin
          res.byte_role           = ccp_pkg::ROLE_KIND;
          st_next.phase           = ccp_pkg::PH_IDX1;
          st_next.field_remaining = ccp_pkg::IDX_LEN;
          st_next.field_position  = 16'd0;
        end
        ccp_pkg::PH_TEXT, ccp_pkg::PH_NUMERIC, ccp_pkg::PH_IDX1, ccp_pkg::PH_IDX2: begin
          res.byte_role = (st.phase == ccp_pkg::PH_TEXT)    ? ccp_pkg::ROLE_TEXT    :
                          (st.phase == ccp_pkg::PH_NUMERIC) ? ccp_pkg::ROLE_NUMERIC :
                          (st.phase == ccp_pkg::PH_IDX1)    ? ccp_pkg::ROLE_IDX1    :
                                                              ccp_pkg::ROLE_IDX2;
          res.field_offset        = st.field_position;
          st_next.field_position  = st.field_position + 16'd1;
          st_next.field_remaining = rem_dec;
          if (rem_dec == 16'd0) begin
            if (st.phase == ccp_pkg::PH_IDX1 &&
                (st.current_tag == ccp_pkg::TAG_FIELDREF ||
                 st.current_tag == ccp_pkg::TAG_METHODREF ||
                 st.current_tag == ccp_pkg::TAG_IFMETHODREF ||
                 st.current_tag == ccp_pkg::TAG_NAMETYPE ||
                 st.current_tag == ccp_pkg::TAG_DYNAMIC ||
                 st.current_tag == ccp_pkg::TAG_INVOKEDYN)) begin
              st_next.phase           = ccp_pkg::PH_IDX2;
              st_next.field_remaining = ccp_pkg::IDX_LEN;
              st_next.field_position  = 16'd0;
            end else if (st.phase == ccp_pkg::PH_NUMERIC &&
                         (st.current_tag == ccp_pkg::TAG_LONG ||
                          st.current_tag == ccp_pkg::TAG_DOUBLE)) begin
              res.entry_complete = 1'b1;
              if (sum1 >= pool17) begin
                // wide entry has no room for its second slot
                st_next.phase        = ccp_pkg::PH_DONE;
                st_next.final_status = ccp_pkg::ST_BAD_COUNT;
                res.status           = ccp_pkg::ST_BAD_COUNT;
              end else begin
                st_next.current_slot = sum2[15:0];
                if (sum2 >= pool17) begin
                  st_next.phase        = ccp_pkg::PH_DONE;
                  st_next.final_status = ccp_pkg::ST_COMPLETE;
                  res.status           = ccp_pkg::ST_COMPLETE;
                end else begin
                  st_next.phase = ccp_pkg::PH_TAG;
                end
              end
            end else begin
              res.entry_complete   = 1'b1;
              st_next.current_slot = sum1[15:0];
              if (sum1 >= pool17) begin
                st_next.phase        = ccp_pkg::PH_DONE;
                st_next.final_status = ccp_pkg::ST_COMPLETE;
                res.status           = ccp_pkg::ST_COMPLETE;
              end else begin
                st_next.phase = ccp_pkg::PH_TAG;
              end
            end
          end
        end
        default: begin
          st_next.phase = ccp_pkg::PH_DONE;
          res.status    = st.final_status;
          if (end_marker) begin
            res.byte_echo = 8'd0;
          end
        end
      endcase
    end
  end

endmodule

// File: rtl/class_constant_pool_parser_top.sv
// ----------------------------------------------------------------------------
// class_constant_pool_parser_top
// Labels each constant pool byte with slot, tag, role, offset and status.
// ----------------------------------------------------------------------------
// Path: an accepted input word passes through the input register, then the
//   result register fed by the parser step logic.
// Throughput: 1 word per cycle; the result register stalls only on out ready.
// Reset: synchronous rst clears both valid flags and the parser state to
//   "expect first count byte", pool count, slot, tag and status zero.
// ----------------------------------------------------------------------------
module class_constant_pool_parser_top (
  input  logic      clk,
  input  logic      rst,
  ccp_in_if.sink    in_ch,
  ccp_out_if.source out_ch
);

  logic                 s1_valid;
  logic [7:0]           s1_byte;
  logic                 s1_end;
  logic                 out_valid;
  ccp_pkg::ccp_result_t out_res;
  ccp_pkg::ccp_state_t  st;
  ccp_pkg::ccp_state_t  st_next;
  ccp_pkg::ccp_result_t res;
  logic                 advance;
  logic                 s1_ready;

  assign advance  = !out_valid || out_ch.ready;
  assign s1_ready = !s1_valid || advance;

  ccp_step u_step (
    .st         (st),
    .byte_value (s1_byte),
    .end_marker (s1_end),
    .st_next    (st_next),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= ccp_pkg::CCP_STATE_RESET;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_ch.valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          st <= st_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && s1_ready) begin
      s1_byte <= in_ch.byte_value;
      s1_end  <= in_ch.end_marker;
    end
    if (advance && s1_valid) begin
      out_res <= res;
    end
  end

  assign in_ch.ready           = s1_ready;
  assign out_ch.valid          = out_valid;
  assign out_ch.slot_index     = out_res.slot_index;
  assign out_ch.entry_tag      = out_res.entry_tag;
  assign out_ch.byte_role      = out_res.byte_role;
  assign out_ch.field_offset   = out_res.field_offset;
  assign out_ch.byte_echo      = out_res.byte_echo;
  assign out_ch.entry_complete = out_res.entry_complete;
  assign out_ch.status         = out_res.status;

endmodule

// File: rtl/ccp_checker.sv
// ----------------------------------------------------------------------------
// ccp_checker
// Port-level assertions for the constant pool parser, bound to the top level.
// ----------------------------------------------------------------------------
module ccp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] slot_index,
  input logic [3:0]  byte_role,
  input logic [2:0]  status
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;
  logic       ended;
  logic [2:0] held_status;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending     <= 2'd0;
      ended       <= 1'b0;
      held_status <= ccp_pkg::ST_BUSY;
    end else begin
      if (in_acc && !out_acc && pending != 2'd3) begin
        pending <= pending + 2'd1;
      end else if (!in_acc && out_acc && pending != 2'd0) begin
        pending <= pending - 2'd1;
      end
      if (out_acc && !ended && status != ccp_pkg::ST_BUSY) begin
        ended       <= 1'b1;
        held_status <= status;
      end
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(slot_index) && $stable(status))
    else $error("result word changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> pending != 2'd0)
    else $error("result word without a pending input word");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending <= 2'd2)
    else $error("more than two words in flight");

  a_sticky: assert property (@(posedge clk) disable iff (rst)
    out_acc && ended |-> status == held_status && byte_role == ccp_pkg::ROLE_IGNORED)
    else $error("status or role changed after the pool ended");

endmodule

bind class_constant_pool_parser_top ccp_checker u_ccp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .slot_index (out_ch.slot_index),
  .byte_role  (out_ch.byte_role),
  .status     (out_ch.status)
);
